[src/pidc_pkg.sv]
// Shared types and constants for the positional PID block.
// No dependencies; imported by the drive interface and every module.
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int GAIN_W     = 16;  // gains and setpoint
  localparam int LIMIT_W    = 8;   // integral clamp magnitude
  localparam int SUM_W      = 9;   // clamped integral, signed, holds +/-255
  localparam int DRIVE_W    = 32;  // controller output
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd166;

endpackage

[src/pidc_if.sv]
// Valid/ready channel interfaces: measurement samples in, drive values out.
// Depends on pidc_pkg for the drive width.
`timescale 1ns / 1ps

interface pidc_sample_if #(
  parameter int MEAS_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [MEAS_WIDTH-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface pidc_drive_if import pidc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

[src/pidc_integ.sv]
// Error, clamped integral and error difference for one sample.
// Depends on pidc_pkg; used by positional_pid_integral_clamp.
`timescale 1ns / 1ps

module pidc_integ import pidc_pkg::*; #(
  parameter int MEAS_WIDTH = 16
) (
  input  logic signed [GAIN_W-1:0]                                   setpoint,
  input  logic signed [MEAS_WIDTH-1:0]                               measurement,
  input  logic        [LIMIT_W-1:0]                                  integral_limit,
  input  logic signed [SUM_W-1:0]                                    error_sum,
  input  logic signed [((MEAS_WIDTH > GAIN_W) ? MEAS_WIDTH : GAIN_W):0] prior_error,
  output logic signed [((MEAS_WIDTH > GAIN_W) ? MEAS_WIDTH : GAIN_W):0] err,
  output logic signed [SUM_W-1:0]                                    sum,
  output logic signed [((MEAS_WIDTH > GAIN_W) ? MEAS_WIDTH : GAIN_W)+1:0] diff
);

  localparam int ERR_W = ((MEAS_WIDTH > GAIN_W) ? MEAS_WIDTH : GAIN_W) + 1;

  logic signed [ERR_W:0] sum_wide;
  logic signed [ERR_W:0] lim_pos;
  logic signed [ERR_W:0] lim_neg;
  logic signed [ERR_W:0] clamped;

  // ERR_W-1 covers both operands, so the difference cannot overflow
  assign err  = ERR_W'(setpoint) - ERR_W'(measurement);
  assign diff = (ERR_W+1)'(err) - (ERR_W+1)'(prior_error);

  assign sum_wide = (ERR_W+1)'(error_sum) + (ERR_W+1)'(err);
  assign lim_pos  = signed'((ERR_W+1)'(integral_limit));
  assign lim_neg  = -lim_pos;

  // upper bound wins; a zero limit pins the sum at zero
  always_comb begin
    if (sum_wide >= lim_pos) begin
      clamped = lim_pos;
    end else if (sum_wide <= lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = sum_wide;
    end
  end

  assign sum = clamped[SUM_W-1:0];

endmodule

[src/pidc_terms.sv]
// Gain products, their sum and the arithmetic fraction shift.
// Depends on pidc_pkg; used by positional_pid_integral_clamp.
`timescale 1ns / 1ps

module pidc_terms import pidc_pkg::*; #(
  parameter int MEAS_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic signed [GAIN_W-1:0]                                     prop_gain,
  input  logic signed [GAIN_W-1:0]                                     integ_gain,
  input  logic signed [GAIN_W-1:0]                                     deriv_gain,
  input  logic signed [((MEAS_WIDTH > GAIN_W) ? MEAS_WIDTH : GAIN_W):0]   err,
  input  logic signed [SUM_W-1:0]                                      sum,
  input  logic signed [((MEAS_WIDTH > GAIN_W) ? MEAS_WIDTH : GAIN_W)+1:0] diff,
  output logic signed [DRIVE_W-1:0]                                    drive
);

  localparam int ERR_W  = ((MEAS_WIDTH > GAIN_W) ? MEAS_WIDTH : GAIN_W) + 1;
  localparam int PROD_W = GAIN_W + ERR_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int EXT_W  = ACC_W + DRIVE_W;

  logic signed [PROD_W-1:0] p_term;
  logic signed [PROD_W-1:0] i_term;
  logic signed [PROD_W-1:0] d_term;
  logic signed [ACC_W-1:0]  acc;
  logic signed [EXT_W-1:0]  acc_ext;
  logic signed [EXT_W-1:0]  shifted;

  assign p_term = PROD_W'(prop_gain) * PROD_W'(err);
  assign i_term = PROD_W'(integ_gain) * PROD_W'(sum);
  assign d_term = PROD_W'(deriv_gain) * PROD_W'(diff);

  assign acc     = ACC_W'(p_term) + ACC_W'(i_term) + ACC_W'(d_term);
  // widen before the shift so the low word is right for any fraction width
  assign acc_ext = EXT_W'(acc);
  assign shifted = acc_ext >>> GAIN_FRAC_BITS;
  assign drive   = shifted[DRIVE_W-1:0];

endmodule

[src/positional_pid_integral_clamp.sv]
// Positional PID with clamped integral. A sample passes the s0, s1 and s2
// registers to the output. Throughput: one sample per cycle unless command.ready
// stalls it, set by the error/integral feedback register.
// Reset clears the integral, the stored error and the pipeline, and loads
// the gains and setpoint with zero and the integral limit with 166.
`timescale 1ns / 1ps

module positional_pid_integral_clamp import pidc_pkg::*; #(
  parameter int MEAS_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pidc_sample_if.sink           sample,
  pidc_drive_if.source          command
);

  localparam int ERR_W = ((MEAS_WIDTH > GAIN_W) ? MEAS_WIDTH : GAIN_W) + 1;

  // configuration
  logic signed [GAIN_W-1:0] prop_gain;
  logic signed [GAIN_W-1:0] integ_gain;
  logic signed [GAIN_W-1:0] deriv_gain;
  logic signed [GAIN_W-1:0] setpoint;
  logic        [LIMIT_W-1:0] integral_limit;

  // controller state
  logic signed [ERR_W-1:0] prior_error;
  logic signed [SUM_W-1:0] error_sum;

  // pipeline registers
  logic                         s0_valid;
  logic signed [MEAS_WIDTH-1:0] s0_meas;
  logic                         s1_valid;
  logic signed [ERR_W-1:0]      s1_err;
  logic signed [SUM_W-1:0]      s1_sum;
  logic signed [ERR_W:0]        s1_diff;
  logic                         s2_valid;
  logic signed [DRIVE_W-1:0]    s2_drive;

  logic s0_ready;
  logic s1_ready;
  logic s2_ready;
  logic s0_load;
  logic s1_load;
  logic s2_load;

  logic signed [ERR_W-1:0]   err_next;
  logic signed [SUM_W-1:0]   sum_next;
  logic signed [ERR_W:0]     diff_next;
  logic signed [DRIVE_W-1:0] drive_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= '0;
      integ_gain     <= '0;
      deriv_gain     <= '0;
      setpoint       <= '0;
      integral_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PROP_GAIN:      prop_gain      <= cfg_data;
        REG_INTEG_GAIN:     integ_gain     <= cfg_data;
        REG_DERIV_GAIN:     deriv_gain     <= cfg_data;
        REG_SETPOINT:       setpoint       <= cfg_data;
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage takes new data when it is empty or its contents move on
  assign s2_ready = !s2_valid || command.ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s0_ready = !s0_valid || s1_ready;

  assign s0_load = sample.valid && s0_ready;
  assign s1_load = s0_valid && s1_ready;
  assign s2_load = s1_valid && s2_ready;

  assign sample.ready  = s0_ready;
  assign command.valid = s2_valid;
  assign command.drive = s2_drive;

  pidc_integ #(
    .MEAS_WIDTH (MEAS_WIDTH)
  ) u_integ (
    .setpoint       (setpoint),
    .measurement    (s0_meas),
    .integral_limit (integral_limit),
    .error_sum      (error_sum),
    .prior_error    (prior_error),
    .err            (err_next),
    .sum            (sum_next),
    .diff           (diff_next)
  );

  pidc_terms #(
    .MEAS_WIDTH     (MEAS_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_terms (
    .prop_gain  (prop_gain),
    .integ_gain (integ_gain),
    .deriv_gain (deriv_gain),
    .err        (s1_err),
    .sum        (s1_sum),
    .diff       (s1_diff),
    .drive      (drive_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid    <= 1'b0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      prior_error <= '0;
      error_sum   <= '0;
    end else begin
      if (s0_ready) begin
        s0_valid <= sample.valid;
      end
      if (s1_ready) begin
        s1_valid <= s0_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      // state advances once per sample, as it enters the term stage
      if (s1_load) begin
        prior_error <= err_next;
        error_sum   <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_load) begin
      s0_meas <= sample.measurement;
    end
    if (s1_load) begin
      s1_err  <= err_next;
      s1_sum  <= sum_next;
      s1_diff <= diff_next;
    end
    if (s2_load) begin
      s2_drive <= drive_next;
    end
  end

endmodule
